// ===== src/tdd_pkg.sv =====
`default_nettype none

package tdd_pkg;

    localparam int TASK_W  = 6;
    localparam int ACT_W   = 3;
    localparam int LEFT_W  = 7;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // most results one input may emit
    localparam int RESULT_CAP = 64;
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_EDGE   = 3'd2,
        ACT_START  = 3'd3,
        ACT_FINISH = 3'd4
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK        = 2'd0,
        ERR_RANGE     = 2'd1,
        ERR_FULL      = 2'd2,
        ERR_NONE_LEFT = 2'd3
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_SCAN,
        S_SCAN_CHK,
        S_FIN_LEN,
        S_FIN_LST,
        S_FIN_REM,
        S_FIN_CHK,
        S_PUSH,
        S_END
    } t_state;

endpackage

`default_nettype wire

// ===== src/tdd_if.sv =====
`default_nettype none

interface tdd_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdd_pkg::ACT_W-1:0]     action;
    logic [tdd_pkg::TASK_W-1:0]    task_a;
    logic [tdd_pkg::TASK_W-1:0]    task_b;

    modport source (output valid, action, task_a, task_b, input ready);
    modport sink   (input valid, action, task_a, task_b, output ready);
endinterface

interface tdd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          ready_valid;
    logic [tdd_pkg::TASK_W-1:0]    ready_task;
    logic [tdd_pkg::TASK_W-1:0]    assigned_id;
    logic [tdd_pkg::LEFT_W-1:0]    tasks_left;
    logic [tdd_pkg::ERR_W-1:0]     error;
    logic                          last;

    modport source (output valid, ready_valid, ready_task, assigned_id, tasks_left, error, last,
                    input ready);
    modport sink   (input valid, ready_valid, ready_task, assigned_id, tasks_left, error, last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/tdd_ram.sv =====
`default_nettype none

module tdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/task_dependency_dispatcher.sv =====
`default_nettype none
// Steps: clear/create go to the result beat, add edge via EDGE, start per task SCAN,
// SCAN_CHK, PUSH, finish FIN_LEN then per dependent FIN_LST, FIN_REM, FIN_CHK, PUSH.
// Throughput: one input beat at a time; the next beat is taken once the last result
// beat of the current one is in the output register.
// Reset: synchronous, active low; clears totals and handshake state only. Task tables
// are undefined until a create writes them; there is no clearing pass.

module task_dependency_dispatcher #(
    parameter int MAX_TASKS  = 64,
    parameter int MAX_FANOUT = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tdd_in_if.sink     i_in,
    tdd_out_if.source  o_out
);

    import tdd_pkg::*;

    // ---------------------------------------------------------------------
    // Derived widths
    // ---------------------------------------------------------------------
    localparam int ID_W     = $clog2(MAX_TASKS);
    localparam int TOT_W    = $clog2(MAX_TASKS + 1);
    localparam int LEN_W    = $clog2(MAX_FANOUT + 1);
    localparam int FL_DEPTH = MAX_TASKS * MAX_FANOUT;
    localparam int FL_AW    = $clog2(FL_DEPTH);
    localparam int IDX_W    = (TOT_W > LEN_W) ? TOT_W : LEN_W;
    localparam int CMP_W    = (TOT_W > TASK_W) ? TOT_W : TASK_W;

    // ---------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------
    t_state              r_state, n_state;
    t_state              r_ret, n_ret;        // where PUSH resumes
    logic [TOT_W-1:0]    r_total, n_total;    // tasks created
    logic [TOT_W-1:0]    r_outst, n_outst;    // tasks of the run not yet finished
    logic [ID_W-1:0]     r_a, n_a;
    logic [ID_W-1:0]     r_b, n_b;
    logic [ID_W-1:0]     r_d, n_d;            // dependent under test in a finish walk
    logic [FL_AW-1:0]    r_base, n_base;      // task_a's row in the dependent list
    logic [IDX_W-1:0]    r_idx, n_idx;        // scan index / dependent index
    logic [LEN_W-1:0]    r_len, n_len;
    logic [CAP_W-1:0]    r_cnt, n_cnt;        // ready beats taken for this input
    t_err                r_err, n_err;
    logic [TASK_W-1:0]   r_asg, n_asg;

    // Candidate from the step just done, and one ready task held back so that
    // the final one can carry last.
    logic                r_cand, n_cand;
    logic [TASK_W-1:0]   r_cand_task, n_cand_task;
    logic                r_h_vld, n_h_vld;
    logic [TASK_W-1:0]   r_h_task, n_h_task;

    // Output register
    logic                r_o_vld, n_o_vld;
    logic                r_o_rv, n_o_rv;
    logic [TASK_W-1:0]   r_o_task, n_o_task;
    logic [TASK_W-1:0]   r_o_asg, n_o_asg;
    logic [LEFT_W-1:0]   r_o_left, n_o_left;
    logic [ERR_W-1:0]    r_o_err, n_o_err;
    logic                r_o_last, n_o_last;

    // ---------------------------------------------------------------------
    // Task tables
    // ---------------------------------------------------------------------
    logic                inc_we;
    logic [ID_W-1:0]     inc_waddr, inc_raddr;
    logic [COUNT_W-1:0]  inc_wdata, inc_rd;

    logic                rem_we;
    logic [ID_W-1:0]     rem_waddr, rem_raddr;
    logic [COUNT_W-1:0]  rem_wdata, rem_rd;

    logic                len_we;
    logic [ID_W-1:0]     len_waddr, len_raddr;
    logic [LEN_W-1:0]    len_wdata, len_rd;

    logic                fl_we;
    logic [FL_AW-1:0]    fl_waddr, fl_raddr;
    logic [TASK_W-1:0]   fl_wdata, fl_rd;

    tdd_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_TASKS)) u_inc (
        .i_clk   (i_clk),
        .i_we    (inc_we),
        .i_waddr (inc_waddr),
        .i_wdata (inc_wdata),
        .i_raddr (inc_raddr),
        .o_rdata (inc_rd)
    );

    tdd_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_TASKS)) u_rem (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_raddr (rem_raddr),
        .o_rdata (rem_rd)
    );

    tdd_ram #(.WIDTH(LEN_W), .DEPTH(MAX_TASKS)) u_len (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (len_raddr),
        .o_rdata (len_rd)
    );

    tdd_ram #(.WIDTH(TASK_W), .DEPTH(FL_DEPTH)) u_fl (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_waddr (fl_waddr),
        .i_wdata (fl_wdata),
        .i_raddr (fl_raddr),
        .o_rdata (fl_rd)
    );

    // Read ports: an idle cycle fetches what an add-edge or finish needs next,
    // later states fetch by the walk index or by the dependent just read.
    assign inc_raddr = (r_state == S_IDLE) ? ID_W'(i_in.task_b) : ID_W'(r_idx);
    assign rem_raddr = (r_state == S_IDLE) ? ID_W'(i_in.task_b) : ID_W'(fl_rd);
    assign len_raddr = ID_W'(i_in.task_a);
    assign fl_raddr  = r_base + FL_AW'(r_idx);

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    logic accept;
    logic out_free;
    logic a_bad, b_bad;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_o_vld || o_out.ready;

    assign a_bad = CMP_W'(i_in.task_a) >= CMP_W'(r_total);
    assign b_bad = CMP_W'(i_in.task_b) >= CMP_W'(r_total);

    assign o_out.valid       = r_o_vld;
    assign o_out.ready_valid = r_o_rv;
    assign o_out.ready_task  = r_o_task;
    assign o_out.assigned_id = r_o_asg;
    assign o_out.tasks_left  = r_o_left;
    assign o_out.error       = r_o_err;
    assign o_out.last        = r_o_last;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_total     = r_total;
        n_outst     = r_outst;
        n_a         = r_a;
        n_b         = r_b;
        n_d         = r_d;
        n_base      = r_base;
        n_idx       = r_idx;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_asg       = r_asg;
        n_cand      = r_cand;
        n_cand_task = r_cand_task;
        n_h_vld     = r_h_vld;
        n_h_task    = r_h_task;

        // output beat drains when taken
        n_o_vld  = r_o_vld && !o_out.ready;
        n_o_rv   = r_o_rv;
        n_o_task = r_o_task;
        n_o_asg  = r_o_asg;
        n_o_left = r_o_left;
        n_o_err  = r_o_err;
        n_o_last = r_o_last;

        inc_we    = 1'b0;
        inc_waddr = ID_W'(r_total);
        inc_wdata = '0;
        rem_we    = 1'b0;
        rem_waddr = ID_W'(r_total);
        rem_wdata = '0;
        len_we    = 1'b0;
        len_waddr = ID_W'(r_total);
        len_wdata = '0;
        fl_we     = 1'b0;
        fl_waddr  = r_base + FL_AW'(len_rd);
        fl_wdata  = TASK_W'(r_b);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_a     = ID_W'(i_in.task_a);
                    n_b     = ID_W'(i_in.task_b);
                    n_base  = FL_AW'(ID_W'(i_in.task_a)) * FL_AW'(MAX_FANOUT);
                    n_err   = ERR_OK;
                    n_asg   = '0;
                    n_cnt   = '0;
                    n_h_vld = 1'b0;
                    n_idx   = '0;
                    n_state = S_END;
                    case (i_in.action)
                        ACT_CLEAR: begin
                            n_total = '0;
                            n_outst = '0;
                        end
                        ACT_CREATE: begin
                            if (r_total == TOT_W'(MAX_TASKS)) begin
                                n_err = ERR_FULL;
                            end else begin
                                // fresh task: all three per-task entries start at zero
                                inc_we  = 1'b1;
                                rem_we  = 1'b1;
                                len_we  = 1'b1;
                                n_asg   = TASK_W'(r_total);
                                n_total = r_total + TOT_W'(1);
                            end
                        end
                        ACT_EDGE: begin
                            if (a_bad || b_bad) begin
                                n_err = ERR_RANGE;
                            end else begin
                                n_state = S_EDGE;
                            end
                        end
                        ACT_START: begin
                            n_outst = r_total;
                            if (r_total != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_FINISH: begin
                            if (r_outst == '0) begin
                                n_err = ERR_NONE_LEFT;
                            end else if (a_bad) begin
                                n_err = ERR_RANGE;
                            end else begin
                                n_outst = r_outst - TOT_W'(1);
                                n_state = S_FIN_LEN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // fanout length of a, incoming and remaining of b are on the read ports
            S_EDGE: begin
                if (len_rd >= LEN_W'(MAX_FANOUT) || inc_rd >= COUNT_MAX) begin
                    n_err = ERR_FULL;
                end else begin
                    fl_we     = 1'b1;
                    len_we    = 1'b1;
                    len_waddr = r_a;
                    len_wdata = len_rd + LEN_W'(1);
                    inc_we    = 1'b1;
                    inc_waddr = r_b;
                    inc_wdata = inc_rd + COUNT_W'(1);
                    rem_we    = 1'b1;
                    rem_waddr = r_b;
                    rem_wdata = (rem_rd < COUNT_MAX) ? rem_rd + COUNT_W'(1) : rem_rd;
                end
                n_state = S_END;
            end

            // start: copy incoming to remaining, roots become ready
            S_SCAN: begin
                n_state = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                rem_we      = 1'b1;
                rem_waddr   = ID_W'(r_idx);
                rem_wdata   = inc_rd;
                n_cand      = (inc_rd == '0);
                n_cand_task = TASK_W'(r_idx);
                n_idx       = r_idx + IDX_W'(1);
                n_ret       = ((IDX_W+1)'(r_idx) + (IDX_W+1)'(1) < (IDX_W+1)'(r_total))
                              ? S_SCAN : S_END;
                n_state     = S_PUSH;
            end

            // finish: walk a's dependent list
            S_FIN_LEN: begin
                n_len   = len_rd;
                n_idx   = '0;
                n_state = (len_rd == '0) ? S_END : S_FIN_LST;
            end

            S_FIN_LST: begin
                n_state = S_FIN_REM;
            end

            S_FIN_REM: begin
                n_d     = ID_W'(fl_rd);
                n_state = S_FIN_CHK;
            end

            S_FIN_CHK: begin
                // a count already at zero stays there and is not emitted
                if (rem_rd != '0) begin
                    rem_we    = 1'b1;
                    rem_waddr = r_d;
                    rem_wdata = rem_rd - COUNT_W'(1);
                end
                n_cand      = (rem_rd == COUNT_W'(1));
                n_cand_task = TASK_W'(r_d);
                n_idx       = r_idx + IDX_W'(1);
                n_ret       = ((IDX_W+1)'(r_idx) + (IDX_W+1)'(1) < (IDX_W+1)'(r_len))
                              ? S_FIN_LST : S_END;
                n_state     = S_PUSH;
            end

            // A new ready task pushes out the held one if any (not last), then is held; past the cap it is dropped.
            S_PUSH: begin
                if (!r_cand || r_cnt >= CAP_W'(RESULT_CAP)) begin
                    n_state = r_ret;
                end else if (!r_h_vld) begin
                    n_h_vld  = 1'b1;
                    n_h_task = r_cand_task;
                    n_cnt    = r_cnt + CAP_W'(1);
                    n_state  = r_ret;
                end else if (out_free) begin
                    n_o_vld  = 1'b1;
                    n_o_rv   = 1'b1;
                    n_o_task = r_h_task;
                    n_o_asg  = '0;
                    n_o_left = LEFT_W'(r_outst);
                    n_o_err  = ERR_OK;
                    n_o_last = 1'b0;
                    n_h_task = r_cand_task;
                    n_cnt    = r_cnt + CAP_W'(1);
                    n_state  = r_ret;
                end
            end

            // Final beat: the held task, or an empty beat with status.
            S_END: begin
                if (out_free) begin
                    n_o_vld  = 1'b1;
                    n_o_rv   = r_h_vld;
                    n_o_task = r_h_vld ? r_h_task : '0;
                    n_o_asg  = r_h_vld ? '0 : r_asg;
                    n_o_left = LEFT_W'(r_outst);
                    n_o_err  = r_h_vld ? ERR_OK : r_err;
                    n_o_last = 1'b1;
                    n_h_vld  = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_outst <= '0;
            r_h_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_outst <= n_outst;
            r_h_vld <= n_h_vld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret       <= n_ret;
        r_a         <= n_a;
        r_b         <= n_b;
        r_d         <= n_d;
        r_base      <= n_base;
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_cnt       <= n_cnt;
        r_err       <= n_err;
        r_asg       <= n_asg;
        r_cand      <= n_cand;
        r_cand_task <= n_cand_task;
        r_h_task    <= n_h_task;
        r_o_rv      <= n_o_rv;
        r_o_task    <= n_o_task;
        r_o_asg     <= n_o_asg;
        r_o_left    <= n_o_left;
        r_o_err     <= n_o_err;
        r_o_last    <= n_o_last;
    end

endmodule

`default_nettype wire

// ===== src/tdd_chk.sv =====
`default_nettype none

module tdd_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       o_out_ready,
    input wire logic                       o_ready_valid,
    input wire logic [tdd_pkg::TASK_W-1:0] o_ready_task,
    input wire logic [tdd_pkg::TASK_W-1:0] o_assigned_id,
    input wire logic [tdd_pkg::LEFT_W-1:0] o_tasks_left,
    input wire logic [tdd_pkg::ERR_W-1:0]  o_error,
    input wire logic                       o_last
);

    import tdd_pkg::*;

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid && $stable(o_ready_valid)
            && $stable(o_ready_task) && $stable(o_assigned_id) && $stable(o_tasks_left)
            && $stable(o_error) && $stable(o_last))
        else $error("stalled result beat changed");

    // one input at a time: busy right after a beat is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous one in work");

    a_empty_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ready_valid |-> o_ready_task == '0)
        else $error("task id on a beat without a ready task");

    a_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ready_valid |-> o_error == ERR_OK && o_assigned_id == '0)
        else $error("ready task beat carries status");

endmodule

bind task_dependency_dispatcher tdd_chk u_tdd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .o_out_valid   (o_out.valid),
    .o_out_ready   (o_out.ready),
    .o_ready_valid (o_out.ready_valid),
    .o_ready_task  (o_out.ready_task),
    .o_assigned_id (o_out.assigned_id),
    .o_tasks_left  (o_out.tasks_left),
    .o_error       (o_out.error),
    .o_last        (o_out.last)
);

`default_nettype wire
